/* sv/cfm_pkg.sv */
// ----------------------------------------------------------------------------
// cfm_pkg: shared types, constants and functions of the field map evaluator
// Holds the fixed-point constants, the CORDIC arctangent table, the CORDIC
// step and angle reduction functions and the structs passed between modules.
// ----------------------------------------------------------------------------
package cfm_pkg;

   // Output field width and number of CORDIC micro-rotations.
   localparam int DATA_WIDTH    = 32;
   localparam int CORDIC_STAGES = 24;
   localparam int STEP_W        = $clog2(CORDIC_STAGES);

   // CORDIC vector width (Q2.30 with headroom) and angle width.
   localparam int CW = 34;
   localparam int AW = 36;

   // Tangent divider: numerator is |sin| scaled by 2^24.
   localparam int DIV_BITS  = CW + 24;
   localparam int DIV_CNT_W = $clog2(DIV_BITS);

   // Configuration port index width.
   localparam int CSR_IDX_W = 4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_MODE     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_RADIUS  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_Z_WIN   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_BASE_FIELD     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_AXIAL_GRADIENT = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SPLIT_ANGLE    = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SPLIT_RAMP     = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INV_X_SCALE    = 4'd7;

   // Field mode codes. Any other code behaves as the axial gradient mode.
   localparam logic [1:0] MODE_ALONG_Y = 2'd1;
   localparam logic [1:0] MODE_OUTLETS = 2'd2;

   // Angle constants in Q2.30.
   localparam logic signed [AW-1:0] PI_Q30      = AW'(64'sd3373259426);
   localparam logic signed [AW-1:0] HALF_PI_Q30 = AW'(64'sd1686629713);
   localparam logic signed [CW-1:0] GAIN_Q30    = CW'(64'sd652032874);
   localparam logic signed [31:0]   I32_MAX     = 32'sd2147483647;

   // Saturation bounds of the output fields.
   localparam logic signed [71:0] SAT_HI = (72'sd1 <<< (DATA_WIDTH - 1)) - 72'sd1;
   localparam logic signed [71:0] SAT_LO = -(72'sd1 <<< (DATA_WIDTH - 1));

   // Arctangent of 2^-i in Q2.30.
   localparam logic [31:0] ATAN_TAB [32] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
      32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
      32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
      32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
      32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
      32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
      32'h00000001, 32'h00000000
   };

   // Live configuration as seen by the datapath.
   typedef struct packed {
      logic [1:0]         field_mode;
      logic signed [31:0] z_min;
      logic signed [31:0] z_max;
      logic signed [31:0] base_field;
      logic signed [31:0] axial_gradient;
      logic signed [31:0] split_angle;
      logic signed [31:0] ramp_start;
      logic [31:0]        inv_len;
      logic signed [31:0] inv_x_scale;
      logic signed [31:0] tan_angle;
      logic [61:0]        radius_sq;
      logic               flare;
   } cfg_type;

   // CORDIC vector and residual angle.
   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [AW-1:0] t;
   } cordic_type;

   // Angle folded into [-pi/2, pi/2] and the sign flip it implies.
   typedef struct packed {
      logic signed [AW-1:0] t;
      logic                 neg;
   } reduce_type;

   // Per-point data carried alongside the CORDIC pipeline.
   typedef struct packed {
      logic                         in_region;
      logic                         x_neg;
      logic                         neg;
      logic [30:0]                  strength;
      logic signed [DATA_WIDTH-1:0] bx;
      logic signed [DATA_WIDTH-1:0] by;
      logic signed [DATA_WIDTH-1:0] bz;
   } side_type;

   // Tangent unit states.
   typedef enum logic [2:0] {
      TAN_IDLE,
      TAN_ROTATE,
      TAN_PREP,
      TAN_DIVIDE,
      TAN_FINISH
   } tan_state_type;

   // Fold an angle of at most about 8 rad by multiples of pi; three steps cover it.
   function automatic reduce_type cordic_reduce(input logic signed [AW-1:0] t_in);
      reduce_type r;
      r.t   = t_in;
      r.neg = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (r.t > HALF_PI_Q30) begin
            r.t   = r.t - PI_Q30;
            r.neg = ~r.neg;
         end else if (r.t < -HALF_PI_Q30) begin
            r.t   = r.t + PI_Q30;
            r.neg = ~r.neg;
         end
      end
      return r;
   endfunction

   // One CORDIC micro-rotation toward a zero residual angle.
   function automatic cordic_type cordic_rotate(input cordic_type v, input logic [4:0] i);
      cordic_type           r;
      logic signed [CW-1:0] vx;
      logic signed [CW-1:0] vy;
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [AW-1:0] vt;
      logic signed [AW-1:0] at;
      vx = v.x;
      vy = v.y;
      vt = v.t;
      dx = vy >>> i;
      dy = vx >>> i;
      at = AW'(ATAN_TAB[i]);
      if (vt >= 0) begin
         r.x = vx - dx;
         r.y = vy + dy;
         r.t = vt - at;
      end else begin
         r.x = vx + dx;
         r.y = vy - dy;
         r.t = vt + at;
      end
      return r;
   endfunction

   // Saturate a wide signed value to the output field width.
   function automatic logic signed [DATA_WIDTH-1:0] sat_data(input logic signed [71:0] v);
      logic signed [71:0] r;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end else begin
         r = v;
      end
      return r[DATA_WIDTH-1:0];
   endfunction

endpackage

/* sv/collimation_field_map_eval.sv */
// ----------------------------------------------------------------------------
// collimation_field_map_eval: magnetic field at a point of a collimator
// Returns the field vector and an in-region flag for each point (x, y, z).
// ----------------------------------------------------------------------------
// The evaluator accepts one point per clock while the tangent unit is idle and
// no finished result is held, and passes it through 7 arithmetic stages, one
// stage per CORDIC micro-rotation and two output stages; the point rate is set by
// the fully pipelined datapath, in which no stage has more than one multiplier in
// series. A stall on the result side holds the whole pipeline.
// After a write of split_angle the tangent unit runs (an iterative CORDIC plus a
// one-bit-a-cycle divider), and req_stall stays high until it is done; other
// writes take effect at once, but the squared radius is registered after them.
module collimation_field_map_eval (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [31:0]                    req_x_pos,
   input  logic signed [31:0]                    req_y_pos,
   input  logic signed [31:0]                    req_z_pos,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [cfm_pkg::DATA_WIDTH-1:0] rsp_field_x,
   output logic signed [cfm_pkg::DATA_WIDTH-1:0] rsp_field_y,
   output logic signed [cfm_pkg::DATA_WIDTH-1:0] rsp_field_z,
   output logic                                  rsp_in_region,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cfm_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [63:0]                           csr_data
);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } s1_type;

   typedef struct packed {
      logic [63:0]        d2x;
      logic [63:0]        d2y;
      logic signed [63:0] gz;
      logic signed [63:0] gx;
      logic signed [63:0] gy;
      logic signed [63:0] xw;
      logic [31:0]        diff_pos;
      logic               z_ok;
      logic               x_neg;
   } s2_type;

   typedef struct packed {
      logic               in_region;
      logic               x_neg;
      logic [30:0]        strength;
      logic [31:0]        ramp;
      logic signed [47:0] lin_x;
      logic signed [47:0] lin_y;
      logic signed [32:0] xw16;
   } s3_type;

   typedef struct packed {
      logic               in_region;
      logic               x_neg;
      logic [30:0]        strength;
      logic signed [47:0] lin_x;
      logic signed [47:0] lin_y;
      logic signed [31:0] tilt;
      logic signed [32:0] w;
   } s4_type;

   typedef struct packed {
      logic                            in_region;
      logic                            x_neg;
      logic [30:0]                     strength;
      logic signed [47:0]              lin_x;
      logic signed [47:0]              lin_y;
      cfm_pkg::reduce_type             red;
      logic signed [32:0]              tw;
   } s5_type;

   typedef struct packed {
      logic                            in_region;
      logic                            x_neg;
      logic [30:0]                     strength;
      logic signed [47:0]              lin_x;
      logic signed [47:0]              lin_y;
      cfm_pkg::reduce_type             red;
      logic signed [39:0]              term;
   } s6_type;

   typedef struct packed {
      cfm_pkg::side_type   side;
      logic signed [cfm_pkg::AW-1:0] t;
   } s7_type;

   typedef struct packed {
      cfm_pkg::side_type  side;
      logic signed [65:0] ac;
      logic signed [65:0] as;
   } p1_type;

   cfm_pkg::cfg_type cfg;
   logic             busy;
   logic             advance;
   logic             accept;

   logic   v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, p1_vld_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;
   s7_type s7_ff, s7_in;
   p1_type p1_ff, p1_in;

   cfm_pkg::cordic_type cd_in_vec;
   logic                cd_out_valid;
   cfm_pkg::cordic_type cd_out_vec;
   cfm_pkg::side_type   cd_out_side;

   logic                                  rsp_valid_ff;
   logic signed [cfm_pkg::DATA_WIDTH-1:0] fx_ff, fx_in;
   logic signed [cfm_pkg::DATA_WIDTH-1:0] fy_ff, fy_in;
   logic signed [cfm_pkg::DATA_WIDTH-1:0] fz_ff, fz_in;
   logic                                  inr_ff, inr_in;

   // Registers and tangent unit.
   cfm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .busy      (busy)
   );

   // Flow control: every stage moves unless a finished result is held.
   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~advance | busy;
   assign accept    = req_valid & ~req_stall;

   // Stage 1: capture the point.
   always_comb begin
      s1_in.x = req_x_pos;
      s1_in.y = req_y_pos;
      s1_in.z = req_z_pos;
   end

   // Stage 2: squares, gradient products and ramp offset.
   always_comb begin
      logic [31:0]        ax;
      logic [31:0]        ay;
      logic signed [31:0] zc;
      logic signed [32:0] diff;
      ax = s1_ff.x[31] ? (~s1_ff.x + 32'd1) : s1_ff.x;
      ay = s1_ff.y[31] ? (~s1_ff.y + 32'd1) : s1_ff.y;
      zc = (s1_ff.z > 0) ? s1_ff.z : 32'sd0;
      diff = 33'(s1_ff.z) - 33'(cfg.ramp_start);
      s2_in.d2x      = 64'(ax) * 64'(ax);
      s2_in.d2y      = 64'(ay) * 64'(ay);
      s2_in.gz       = 64'(cfg.axial_gradient) * 64'(zc);
      s2_in.gx       = 64'(cfg.axial_gradient) * 64'(s1_ff.x);
      s2_in.gy       = 64'(cfg.axial_gradient) * 64'(s1_ff.y);
      s2_in.xw       = 64'(s1_ff.x) * 64'(cfg.inv_x_scale);
      s2_in.diff_pos = (diff > 0) ? diff[31:0] : 32'd0;
      s2_in.z_ok     = (s1_ff.z >= cfg.z_min) && (s1_ff.z <= cfg.z_max);
      s2_in.x_neg    = s1_ff.x[31];
   end

   // Stage 3: region test, axial strength, ramp and rounded linear terms.
   always_comb begin
      logic [64:0]        d2;
      logic signed [63:0] gzr;
      logic signed [63:0] asum;
      logic [63:0]        p;
      logic signed [63:0] gxr;
      logic signed [63:0] gyr;
      logic signed [63:0] xc;
      logic signed [63:0] xr;
      d2   = 65'(s2_ff.d2x) + 65'(s2_ff.d2y);
      gzr  = (s2_ff.gz + 64'sd32768) >>> 16;
      asum = 64'(cfg.base_field) + gzr;
      p    = 64'(s2_ff.diff_pos) * 64'(cfg.inv_len);
      gxr  = (s2_ff.gx + 64'sd65536) >>> 17;
      gyr  = (s2_ff.gy + 64'sd65536) >>> 17;
      if (s2_ff.xw > 64'sd140737488355328) begin
         xc = 64'sd140737488355328;
      end else if (s2_ff.xw < -64'sd140737488355328) begin
         xc = -64'sd140737488355328;
      end else begin
         xc = s2_ff.xw;
      end
      xr = (xc + 64'sd32768) >>> 16;
      s3_in.in_region = s2_ff.z_ok && (d2 <= 65'(cfg.radius_sq));
      s3_in.x_neg     = s2_ff.x_neg;
      if (asum < 0) begin
         s3_in.strength = '0;
      end else if (asum > 64'(cfm_pkg::I32_MAX)) begin
         s3_in.strength = 31'h7FFF_FFFF;
      end else begin
         s3_in.strength = asum[30:0];
      end
      s3_in.ramp  = (p[63:32] != 32'd0) ? 32'h8000_0000 : p[32:1];
      s3_in.lin_x = gxr[47:0];
      s3_in.lin_y = gyr[47:0];
      s3_in.xw16  = xr[32:0];
   end

   // Stage 4: tilt angle and flare weight.
   always_comb begin
      logic signed [32:0] rs;
      logic signed [64:0] pt;
      logic signed [64:0] tr;
      logic signed [65:0] pw;
      logic signed [65:0] wr;
      rs = $signed({1'b0, s3_ff.ramp});
      pt = 65'(cfg.split_angle) * 65'(rs);
      tr = (pt + 65'sd1073741824) >>> 31;
      pw = 66'(rs) * 66'(s3_ff.xw16);
      wr = (pw + 66'sd1073741824) >>> 31;
      s4_in.in_region = s3_ff.in_region;
      s4_in.x_neg     = s3_ff.x_neg;
      s4_in.strength  = s3_ff.strength;
      s4_in.lin_x     = s3_ff.lin_x;
      s4_in.lin_y     = s3_ff.lin_y;
      s4_in.tilt      = cfg.flare ? tr[31:0] : cfg.split_angle;
      s4_in.w         = wr[32:0];
   end

   // Stage 5: fold the tilt angle and scale the weight by the tangent.
   always_comb begin
      logic signed [64:0] ptw;
      logic signed [64:0] twr;
      ptw = 65'(cfg.tan_angle) * 65'(s4_ff.w);
      twr = (ptw + 65'sd1073741824) >>> 31;
      s5_in.in_region = s4_ff.in_region;
      s5_in.x_neg     = s4_ff.x_neg;
      s5_in.strength  = s4_ff.strength;
      s5_in.lin_x     = s4_ff.lin_x;
      s5_in.lin_y     = s4_ff.lin_y;
      s5_in.red       = cfm_pkg::cordic_reduce(cfm_pkg::AW'(s4_ff.tilt) <<< 2);
      s5_in.tw        = twr[32:0];
   end

   // Stage 6: flare term, strength times weighted tangent.
   always_comb begin
      logic signed [64:0] pa;
      logic signed [64:0] ter;
      pa  = 65'($signed({1'b0, s5_ff.strength})) * 65'(s5_ff.tw);
      ter = (pa + 65'sd8388608) >>> 24;
      s6_in.in_region = s5_ff.in_region;
      s6_in.x_neg     = s5_ff.x_neg;
      s6_in.strength  = s5_ff.strength;
      s6_in.lin_x     = s5_ff.lin_x;
      s6_in.lin_y     = s5_ff.lin_y;
      s6_in.red       = s5_ff.red;
      s6_in.term      = cfg.flare ? ter[39:0] : 40'sd0;
   end

   // Stage 7: results of the two non-rotating modes.
   always_comb begin
      logic signed [71:0] a72;
      a72 = 72'($signed({1'b0, s6_ff.strength}));
      s7_in.side.in_region = s6_ff.in_region;
      s7_in.side.x_neg     = s6_ff.x_neg;
      s7_in.side.neg       = s6_ff.red.neg;
      s7_in.side.strength  = s6_ff.strength;
      s7_in.t              = s6_ff.red.t;
      if (cfg.field_mode == cfm_pkg::MODE_ALONG_Y) begin
         s7_in.side.bx = cfm_pkg::sat_data(72'(s6_ff.term));
         s7_in.side.by = cfm_pkg::sat_data(a72);
         s7_in.side.bz = '0;
      end else begin
         s7_in.side.bx = cfm_pkg::sat_data(72'(s6_ff.term) - 72'(s6_ff.lin_x));
         s7_in.side.by = cfm_pkg::sat_data(-72'(s6_ff.lin_y));
         s7_in.side.bz = cfm_pkg::sat_data(a72);
      end
   end

   // Front stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   // Rotate the unit vector by the tilt angle.
   always_comb begin
      cd_in_vec.x = cfm_pkg::GAIN_Q30;
      cd_in_vec.y = '0;
      cd_in_vec.t = s7_ff.t;
   end

   cfm_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v7_ff),
      .in_vec    (cd_in_vec),
      .in_side   (s7_ff.side),
      .out_valid (cd_out_valid),
      .out_vec   (cd_out_vec),
      .out_side  (cd_out_side)
   );

   // Post stage 1: undo the fold and scale cos and sin by the strength.
   always_comb begin
      logic signed [cfm_pkg::CW-1:0] c;
      logic signed [cfm_pkg::CW-1:0] s;
      logic signed [31:0]            a;
      c = cd_out_side.neg ? -cd_out_vec.x : cd_out_vec.x;
      s = cd_out_side.neg ? -cd_out_vec.y : cd_out_vec.y;
      a = $signed({1'b0, cd_out_side.strength});
      p1_in.side = cd_out_side;
      p1_in.ac   = 66'(a) * 66'(c);
      p1_in.as   = 66'(a) * 66'(s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
      end else if (advance) begin
         p1_vld_ff <= cd_out_valid;
      end
      if (advance) begin
         p1_ff <= p1_in;
      end
   end

   // Post stage 2: mode select, region gating and saturation.
   always_comb begin
      logic signed [65:0] bx;
      logic signed [65:0] bz;
      bx = (p1_ff.ac + 66'sd536870912) >>> 30;
      bz = (p1_ff.as + 66'sd536870912) >>> 30;
      if (p1_ff.side.x_neg) begin
         bx = -bx;
      end
      if (!p1_ff.side.in_region) begin
         fx_in  = '0;
         fy_in  = '0;
         fz_in  = '0;
         inr_in = 1'b0;
      end else if (cfg.field_mode == cfm_pkg::MODE_OUTLETS) begin
         fx_in  = cfm_pkg::sat_data(72'(bx));
         fy_in  = '0;
         fz_in  = cfm_pkg::sat_data(72'(bz));
         inr_in = 1'b1;
      end else begin
         fx_in  = p1_ff.side.bx;
         fy_in  = p1_ff.side.by;
         fz_in  = p1_ff.side.bz;
         inr_in = 1'b1;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= p1_vld_ff;
      end
      if (advance) begin
         fx_ff  <= fx_in;
         fy_ff  <= fy_in;
         fz_ff  <= fz_in;
         inr_ff <= inr_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_field_x   = fx_ff;
   assign rsp_field_y   = fy_ff;
   assign rsp_field_z   = fz_ff;
   assign rsp_in_region = inr_ff;

endmodule

/* sv/cfm_csr.sv */
// ----------------------------------------------------------------------------
// cfm_csr: configuration registers and tangent unit
// Stores the registers, keeps the squared radius, and computes tan of the
// split angle after each write of it with an iterative CORDIC and a bit-serial
// divider. busy is high while the tangent is being worked out.
// ----------------------------------------------------------------------------
module cfm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cfm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                   csr_data,
   output cfm_pkg::cfg_type              cfg,
   output logic                          busy
);

   logic [1:0]         field_mode_ff;
   logic [30:0]        radius_ff;
   logic signed [31:0] z_min_ff;
   logic signed [31:0] z_max_ff;
   logic signed [31:0] base_ff;
   logic signed [31:0] grad_ff;
   logic signed [31:0] angle_ff;
   logic signed [31:0] ramp_start_ff;
   logic [31:0]        inv_len_ff;
   logic signed [31:0] inv_x_scale_ff;
   logic [61:0]        radius_sq_ff;

   cfm_pkg::tan_state_type               state_ff, state_in;
   cfm_pkg::cordic_type                  vec_ff, vec_in;
   logic                                 neg_ff, neg_in;
   logic [cfm_pkg::STEP_W-1:0]           step_ff, step_in;
   logic [cfm_pkg::CW-1:0]               den_ff, den_in;
   logic [cfm_pkg::DIV_BITS-1:0]         num_ff, num_in;
   logic [cfm_pkg::CW-1:0]               rem_ff, rem_in;
   logic [cfm_pkg::DIV_BITS-1:0]         quo_ff, quo_in;
   logic [cfm_pkg::DIV_CNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 qneg_ff, qneg_in;
   logic signed [31:0]                   tan_ff, tan_in;

   logic wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;
   assign busy      = (state_ff != cfm_pkg::TAN_IDLE);

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         field_mode_ff  <= '0;
         radius_ff      <= '0;
         z_min_ff       <= '0;
         z_max_ff       <= '0;
         base_ff        <= '0;
         grad_ff        <= '0;
         angle_ff       <= '0;
         ramp_start_ff  <= '0;
         inv_len_ff     <= '0;
         inv_x_scale_ff <= '0;
      end else if (wr) begin
         unique case (csr_index)
            cfm_pkg::REG_FIELD_MODE:     field_mode_ff  <= csr_data[1:0];
            cfm_pkg::REG_ACTIVE_RADIUS:  radius_ff      <= csr_data[30:0];
            cfm_pkg::REG_ACTIVE_Z_WIN: begin
               z_min_ff <= csr_data[31:0];
               z_max_ff <= csr_data[63:32];
            end
            cfm_pkg::REG_BASE_FIELD:     base_ff        <= csr_data[31:0];
            cfm_pkg::REG_AXIAL_GRADIENT: grad_ff        <= csr_data[31:0];
            cfm_pkg::REG_SPLIT_ANGLE:    angle_ff       <= csr_data[31:0];
            cfm_pkg::REG_SPLIT_RAMP: begin
               ramp_start_ff <= csr_data[31:0];
               inv_len_ff    <= csr_data[63:32];
            end
            cfm_pkg::REG_INV_X_SCALE:    inv_x_scale_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // The squared radius is registered from the radius register, in the cycle after it.
   always_ff @(posedge clock) begin
      radius_sq_ff <= 62'(radius_ff) * 62'(radius_ff);
   end

   // Tangent unit: next state and datapath.
   always_comb begin
      cfm_pkg::reduce_type         red;
      logic signed [cfm_pkg::CW-1:0] c;
      logic signed [cfm_pkg::CW-1:0] s;
      logic [cfm_pkg::CW-1:0]        s_mag;
      logic [cfm_pkg::CW:0]          trial;
      logic [30:0]                   mag;
      state_in = state_ff;
      vec_in   = vec_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      den_in   = den_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      qneg_in  = qneg_ff;
      tan_in   = tan_ff;
      red      = cfm_pkg::cordic_reduce(cfm_pkg::AW'($signed(csr_data[31:0])) <<< 2);
      c        = neg_ff ? -vec_ff.x : vec_ff.x;
      s        = neg_ff ? -vec_ff.y : vec_ff.y;
      if (c < 0) begin
         c = -c;
         s = -s;
      end
      s_mag = s[cfm_pkg::CW-1] ? cfm_pkg::CW'(-s) : cfm_pkg::CW'(s);
      trial = {rem_ff, num_ff[cfm_pkg::DIV_BITS-1]};
      mag   = (quo_ff > cfm_pkg::DIV_BITS'(cfm_pkg::I32_MAX)) ? 31'h7FFF_FFFF : quo_ff[30:0];

      if (wr && (csr_index == cfm_pkg::REG_SPLIT_ANGLE)) begin
         // A new angle restarts the unit.
         vec_in.x = cfm_pkg::GAIN_Q30;
         vec_in.y = '0;
         vec_in.t = red.t;
         neg_in   = red.neg;
         step_in  = '0;
         state_in = cfm_pkg::TAN_ROTATE;
      end else begin
         unique case (state_ff)
            cfm_pkg::TAN_IDLE: ;
            cfm_pkg::TAN_ROTATE: begin
               vec_in  = cfm_pkg::cordic_rotate(vec_ff, 5'(step_ff));
               step_in = step_ff + 1'b1;
               if (step_ff == cfm_pkg::STEP_W'(cfm_pkg::CORDIC_STAGES - 1)) begin
                  state_in = cfm_pkg::TAN_PREP;
               end
            end
            cfm_pkg::TAN_PREP: begin
               if (c == 0) begin
                  // Pole: saturate with the sign of sin.
                  tan_in   = (s >= 0) ? cfm_pkg::I32_MAX : -cfm_pkg::I32_MAX;
                  state_in = cfm_pkg::TAN_IDLE;
               end else begin
                  den_in   = c;
                  num_in   = {s_mag, 24'd0};
                  qneg_in  = (s < 0);
                  rem_in   = '0;
                  quo_in   = '0;
                  cnt_in   = '0;
                  state_in = cfm_pkg::TAN_DIVIDE;
               end
            end
            cfm_pkg::TAN_DIVIDE: begin
               // Restoring division, one quotient bit a cycle.
               if (trial >= {1'b0, den_ff}) begin
                  rem_in = cfm_pkg::CW'(trial - {1'b0, den_ff});
                  quo_in = {quo_ff[cfm_pkg::DIV_BITS-2:0], 1'b1};
               end else begin
                  rem_in = trial[cfm_pkg::CW-1:0];
                  quo_in = {quo_ff[cfm_pkg::DIV_BITS-2:0], 1'b0};
               end
               num_in = {num_ff[cfm_pkg::DIV_BITS-2:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == cfm_pkg::DIV_CNT_W'(cfm_pkg::DIV_BITS - 1)) begin
                  state_in = cfm_pkg::TAN_FINISH;
               end
            end
            cfm_pkg::TAN_FINISH: begin
               tan_in   = qneg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
               state_in = cfm_pkg::TAN_IDLE;
            end
            default: state_in = cfm_pkg::TAN_IDLE;
         endcase
      end
   end

   // Tangent unit registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfm_pkg::TAN_IDLE;
         tan_ff   <= '0;
      end else begin
         state_ff <= state_in;
         tan_ff   <= tan_in;
      end
      vec_ff  <= vec_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
      den_ff  <= den_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      qneg_ff <= qneg_in;
   end

   // Configuration as seen by the datapath.
   always_comb begin
      cfg.field_mode     = field_mode_ff;
      cfg.z_min          = z_min_ff;
      cfg.z_max          = z_max_ff;
      cfg.base_field     = base_ff;
      cfg.axial_gradient = grad_ff;
      cfg.split_angle    = angle_ff;
      cfg.ramp_start     = ramp_start_ff;
      cfg.inv_len        = inv_len_ff;
      cfg.inv_x_scale    = inv_x_scale_ff;
      cfg.tan_angle      = tan_ff;
      cfg.radius_sq      = radius_sq_ff;
      cfg.flare          = (angle_ff != 0) && (inv_len_ff != 0);
   end

endmodule

/* sv/cfm_cordic.sv */
// ----------------------------------------------------------------------------
// cfm_cordic: pipelined CORDIC rotator
// One micro-rotation per register stage, with the point's other data carried
// alongside. All stages move together when advance is high.
// ----------------------------------------------------------------------------
module cfm_cordic (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  cfm_pkg::cordic_type in_vec,
   input  cfm_pkg::side_type   in_side,
   output logic                out_valid,
   output cfm_pkg::cordic_type out_vec,
   output cfm_pkg::side_type   out_side
);

   logic                vld_ff  [cfm_pkg::CORDIC_STAGES];
   cfm_pkg::cordic_type vec_ff  [cfm_pkg::CORDIC_STAGES];
   cfm_pkg::side_type   side_ff [cfm_pkg::CORDIC_STAGES];

   // First stage takes the folded angle.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
      end
      if (advance) begin
         vec_ff[0]  <= cfm_pkg::cordic_rotate(in_vec, 5'd0);
         side_ff[0] <= in_side;
      end
   end

   // Remaining micro-rotation stages.
   for (genvar i = 1; i < cfm_pkg::CORDIC_STAGES; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (advance) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         if (advance) begin
            vec_ff[i]  <= cfm_pkg::cordic_rotate(vec_ff[i-1], 5'(i));
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign out_valid = vld_ff[cfm_pkg::CORDIC_STAGES-1];
   assign out_vec   = vec_ff[cfm_pkg::CORDIC_STAGES-1];
   assign out_side  = side_ff[cfm_pkg::CORDIC_STAGES-1];

endmodule

/* test/collimation_field_map_eval_test.sv */
// ----------------------------------------------------------------------------
// collimation_field_map_eval_test: self-checking bench of the field evaluator
// Drives points through the request channel under a series of register settings,
// predicts every field vector from a fixed table or a bit-exact model of its own
// and compares each result transfer in order, with random stalls on both sides.
// ----------------------------------------------------------------------------
module collimation_field_map_eval_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Register index that the block has no register for.
   localparam logic [cfm_pkg::CSR_IDX_W-1:0] REG_UNUSED = 4'd11;
   localparam int  CYCLE_LIMIT = 400000;
   localparam int  DRAIN_CYCLES = 40;
   localparam longint ONE_Q31_L = 64'sd2147483648;
   localparam longint W32_MAX = 64'sd2147483647;

   typedef struct {
      longint bx;
      longint by;
      longint bz;
      logic   in_region;
   } field_vec_type;

   typedef struct {
      int            x;
      int            y;
      int            z;
      logic          typed;
      field_vec_type fixed;
   } point_row_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [31:0] req_x_pos, req_y_pos, req_z_pos;
   logic rsp_valid, rsp_stall;
   logic signed [cfm_pkg::DATA_WIDTH-1:0] rsp_field_x, rsp_field_y, rsp_field_z;
   logic rsp_in_region;
   logic csr_valid, csr_ready;
   logic [cfm_pkg::CSR_IDX_W-1:0] csr_index;
   logic [63:0] csr_data;

   // Shadow copy of the register file.
   logic [1:0]  mode_r;
   logic [30:0] radius_r;
   logic [63:0] zwin_r, ramp_r;
   int          base_r, grad_r, angle_r, xscale_r;

   field_vec_type  expected_fields[$];
   point_row_type  sent_rows[$];
   int             error_count;
   int             cycle_count;
   logic           quiet_mode;
   logic           hold_request;
   int             stall_left;

   collimation_field_map_eval u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Timeout guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("collimation_field_map_eval_test NOT OK");
         $finish;
      end
   end

   function automatic longint round_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_l(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Rotation-mode CORDIC on a Q2.30 angle, giving cos and sin in Q2.30.
   function automatic void rotate_angle(input longint t_in, output longint c,
                                        output longint s);
      longint t, x, y, nx;
      logic   flip;
      t = t_in;
      x = longint'(cfm_pkg::GAIN_Q30);
      y = 0;
      flip = 1'b0;
      while (t > longint'(cfm_pkg::HALF_PI_Q30)) begin
         t -= longint'(cfm_pkg::PI_Q30);
         flip = ~flip;
      end
      while (t < -longint'(cfm_pkg::HALF_PI_Q30)) begin
         t += longint'(cfm_pkg::PI_Q30);
         flip = ~flip;
      end
      for (int i = 0; i < cfm_pkg::CORDIC_STAGES && i < 32; i++) begin
         if (t >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            t -= longint'(cfm_pkg::ATAN_TAB[i]);
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            t += longint'(cfm_pkg::ATAN_TAB[i]);
         end
         x = nx;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint tangent_q24(longint ang);
      longint c, s;
      rotate_angle(ang * 4, c, s);
      if (c < 0) begin
         c = -c;
         s = -s;
      end
      if (c == 0) return s >= 0 ? W32_MAX : -W32_MAX;
      return clamp_l((s <<< 24) / c, -W32_MAX, W32_MAX);
   endfunction

   // Field vector at a point under the current shadow registers.
   function automatic field_vec_type field_at_point(int xi, int yi, int zi);
      field_vec_type r;
      longint x, y, z, ax, ay, zmin, zmax, g, ang, a, ramp, diff, c, s, tilt;
      longint term, xw, w, tw, bx, by, bz;
      longint unsigned d2, p, inv_len;
      logic flare;
      x = xi; y = yi; z = zi;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      zmin = longint'($signed(zwin_r[31:0]));
      zmax = longint'($signed(zwin_r[63:32]));
      g = grad_r;
      ang = angle_r;
      inv_len = ramp_r[63:32];
      flare = (ang != 0) && (inv_len != 0);
      bx = 0; by = 0; bz = 0;
      d2 = longint'(ax * ax) + longint'(ay * ay);
      r = '{0, 0, 0, 1'b0};
      if (d2 > longint'(radius_r) * longint'(radius_r) || z < zmin || z > zmax)
         return r;
      a = clamp_l(longint'(base_r) + round_shift(g * (z > 0 ? z : 0), 16), 0, W32_MAX);
      ramp = 0;
      diff = z - longint'($signed(ramp_r[31:0]));
      if (diff > 0) begin
         p = longint'(diff) * inv_len;
         ramp = (p >= 64'h1_0000_0000) ? ONE_Q31_L : longint'(p >> 1);
      end
      if (mode_r == cfm_pkg::MODE_OUTLETS) begin
         tilt = flare ? round_shift(ang * ramp, 31) : ang;
         rotate_angle(tilt * 4, c, s);
         bx = round_shift(a * c, 30);
         if (x < 0) bx = -bx;
         bz = round_shift(a * s, 30);
      end else begin
         term = 0;
         if (flare) begin
            xw = clamp_l(x * longint'(xscale_r), -(64'sd1 <<< 47), 64'sd1 <<< 47);
            w = round_shift(ramp * round_shift(xw, 16), 31);
            tw = round_shift(tangent_q24(ang) * w, 31);
            term = round_shift(a * tw, 24);
         end
         if (mode_r == cfm_pkg::MODE_ALONG_Y) begin
            bx = term; by = a; bz = 0;
         end else begin
            bx = -round_shift(g * x, 17) + term;
            by = -round_shift(g * y, 17);
            bz = a;
         end
      end
      r.bx = clamp_l(bx, -W32_MAX - 1, W32_MAX);
      r.by = clamp_l(by, -W32_MAX - 1, W32_MAX);
      r.bz = clamp_l(bz, -W32_MAX - 1, W32_MAX);
      r.in_region = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   // On each accepted point, queue its expected field; on each result, check it.
   always @(posedge clock) begin
      point_row_type row;
      field_vec_type want;
      if (!reset && req_valid && !req_stall) begin
         row = sent_rows.pop_front();
         want = row.typed ? row.fixed : field_at_point(row.x, row.y, row.z);
         expected_fields.push_back(want);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_fields.size() == 0) begin
            report_mismatch("unexpected result", 0, 0);
         end else begin
            want = expected_fields.pop_front();
            if (longint'(rsp_field_x) != want.bx)
               report_mismatch("field_x", rsp_field_x, want.bx);
            if (longint'(rsp_field_y) != want.by)
               report_mismatch("field_y", rsp_field_y, want.by);
            if (longint'(rsp_field_z) != want.bz)
               report_mismatch("field_z", rsp_field_z, want.bz);
            if (rsp_in_region != want.in_region)
               report_mismatch("in_region", rsp_in_region, want.in_region);
         end
      end
   end

   // Result-side stall: random bursts, a long hold-off on request, none when quiet.
   always @(negedge clock) begin
      if (hold_request) begin
         stall_left = 300;
         hold_request <= 1'b0;
      end
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 5);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic wait_drained();
      while (expected_fields.size() != 0 || sent_rows.size() != 0) @(negedge clock);
   endtask

   // Register write; only called while nothing is in flight.
   task automatic write_register(logic [cfm_pkg::CSR_IDX_W-1:0] idx, logic [63:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      unique case (idx)
         cfm_pkg::REG_FIELD_MODE:     mode_r = value[1:0];
         cfm_pkg::REG_ACTIVE_RADIUS:  radius_r = value[30:0];
         cfm_pkg::REG_ACTIVE_Z_WIN:   zwin_r = value;
         cfm_pkg::REG_BASE_FIELD:     base_r = value[31:0];
         cfm_pkg::REG_AXIAL_GRADIENT: grad_r = value[31:0];
         cfm_pkg::REG_SPLIT_ANGLE:    angle_r = value[31:0];
         cfm_pkg::REG_SPLIT_RAMP:     ramp_r = value;
         cfm_pkg::REG_INV_X_SCALE:    xscale_r = value[31:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Offer one point and hold it until the transfer; a random gap may follow.
   task automatic send_point(point_row_type row);
      sent_rows.push_back(row);
      req_valid = 1'b1;
      req_x_pos = row.x;
      req_y_pos = row.y;
      req_z_pos = row.z;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (!quiet_mode && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   function automatic int rand_coord(int span);
      unique case ($urandom_range(0, 3))
         0: return $urandom;
         default: return $signed($urandom_range(0, 2 * span)) - span;
      endcase
   endfunction

   function automatic point_row_type random_point();
      point_row_type row;
      int span;
      span = radius_r > 31'h3FFF_FFFF ? 32'h3FFF_FFFF : int'(radius_r);
      row.x = rand_coord(span);
      row.y = rand_coord(span);
      row.z = ($urandom_range(0, 7) == 0) ? int'($urandom) :
              $signed(zwin_r[31:0]) + int'($urandom_range(0, 32'h00FF_FFFF));
      row.typed = 1'b0;
      row.fixed = '{0, 0, 0, 1'b0};
      return row;
   endfunction

   task automatic program_setting(logic [1:0] mode, logic [30:0] radius,
                                  int zmin, int zmax, int base, int grad, int ang,
                                  int ramp_start, int inv_len, int xscale);
      req_valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      write_register(cfm_pkg::REG_FIELD_MODE, 64'(mode));
      write_register(cfm_pkg::REG_ACTIVE_RADIUS, 64'(radius));
      write_register(cfm_pkg::REG_ACTIVE_Z_WIN, {zmax, zmin});
      write_register(cfm_pkg::REG_BASE_FIELD, 64'(unsigned'(base)));
      write_register(cfm_pkg::REG_AXIAL_GRADIENT, 64'(unsigned'(grad)));
      write_register(cfm_pkg::REG_SPLIT_ANGLE, 64'(unsigned'(ang)));
      write_register(cfm_pkg::REG_SPLIT_RAMP, {inv_len, ramp_start});
      write_register(cfm_pkg::REG_INV_X_SCALE, 64'(unsigned'(xscale)));
   endtask

   point_row_type reset_rows[] = '{
      '{0, 0, 0, 1'b1, '{0, 0, 0, 1'b1}},
      '{1, 0, 0, 1'b1, '{0, 0, 0, 1'b0}},
      '{0, -1, 0, 1'b1, '{0, 0, 0, 1'b0}},
      '{0, 0, 1, 1'b1, '{0, 0, 0, 1'b0}},
      '{0, 0, -1, 1'b1, '{0, 0, 0, 1'b0}},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{0, 0, 0, 1'b0}}
   };

   point_row_type edge_rows[] = '{
      '{0, 0, 0, 1'b0, '{0, 0, 0, 1'b0}},
      '{32'h7FFF_FFFF, 0, 0, 1'b0, '{0, 0, 0, 1'b0}},
      '{32'h8000_0000, 0, 0, 1'b0, '{0, 0, 0, 1'b0}},
      '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '{0, 0, 0, 1'b0}},
      '{0, 32'h8000_0000, 32'h8000_0000, 1'b0, '{0, 0, 0, 1'b0}},
      '{32'h8000_0000, 32'h8000_0000, 32'h4000_0000, 1'b0, '{0, 0, 0, 1'b0}},
      '{32'h0001_0000, -32'h0001_0000, 32'h0010_0000, 1'b0, '{0, 0, 0, 1'b0}},
      '{-32'h0100_0000, 32'h0100_0000, -32'h0010_0000, 1'b0, '{0, 0, 0, 1'b0}},
      '{32'h5000_0000, 32'h5000_0000, 32'h0100_0000, 1'b0, '{0, 0, 0, 1'b0}},
      '{-1, 1, 32'h2000_0000, 1'b0, '{0, 0, 0, 1'b0}}
   };

   initial begin
      int count;
      point_row_type row;
      error_count = 0;
      cycle_count = 0;
      quiet_mode = 1'b0;
      hold_request = 1'b0;
      stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_pos = 0; req_y_pos = 0; req_z_pos = 0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = cfm_pkg::REG_FIELD_MODE;
      csr_data = '0;
      mode_r = '0; radius_r = '0; zwin_r = '0; ramp_r = '0;
      base_r = 0; grad_r = 0; angle_r = 0; xscale_r = 0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // All registers at zero: only the origin is inside and its field is zero.
      foreach (reset_rows[i]) send_point(reset_rows[i]);

      // Extremes of the fields under wide open limits, with an ignored write.
      for (int m = 0; m < 3; m++) begin
         program_setting(2'(m), 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                         0, 32'h0001_0000, 32'h7FFF_FFFF);
         write_register(REG_UNUSED, '1);
         foreach (edge_rows[i]) send_point(edge_rows[i]);
      end
      // Empty z window, flare disabled by a zero ramp, pole of the tangent.
      program_setting(cfm_pkg::MODE_OUTLETS, 31'h7FFF_FFFF, 32'h0010_0000, 32'h0000_0000,
                      32'h0100_0000, 0, 32'h1921_FB54, 0, 0, 0);
      foreach (edge_rows[i]) send_point(edge_rows[i]);
      program_setting(cfm_pkg::MODE_ALONG_Y, 31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0100_0000, 32'h0001_0000, 32'h1921_FB54, 0, 32'h0000_1000,
                      32'h4000_0000);
      foreach (edge_rows[i]) send_point(edge_rows[i]);

      // Random settings, each with a run of random points.
      for (int phase = 0; phase < 12; phase++) begin
         if (phase >= 10) quiet_mode = 1'b1;
         program_setting(2'($urandom_range(0, 3)),
                         ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                            31'($urandom_range(32'h0001_0000, 32'h0400_0000)),
                         -int'($urandom_range(0, 32'h0100_0000)),
                         int'($urandom_range(0, 32'h0400_0000)),
                         $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000,
                         ($urandom_range(0, 3) == 0) ? int'($urandom) :
                            $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000,
                         ($urandom_range(0, 4) == 0) ? 0 : int'($urandom),
                         -int'($urandom_range(0, 32'h0080_0000)),
                         ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 32'h0004_0000)),
                         ($urandom_range(0, 4) == 0) ? 0 : int'($urandom));
         count = 130;
         for (int k = 0; k < count; k++) begin
            if (phase == 3 && k == 20) hold_request = 1'b1;
            if (phase == 5 && k == 60) begin
               req_valid = 1'b0;
               wait_drained();
            end
            row = random_point();
            send_point(row);
         end
      end

      req_valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("collimation_field_map_eval_test OK");
      end else begin
         $display("collimation_field_map_eval_test NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
sv/cfm_pkg.sv
sv/cfm_csr.sv
sv/cfm_cordic.sv
sv/collimation_field_map_eval.sv
test/collimation_field_map_eval_test.sv
